### rtl/depth_roi_obstacle_stats_assert.svh
// Assertion macros for the depth region statistics block.
`ifndef DEPTH_ROI_OBSTACLE_STATS_ASSERT_SVH
`define DEPTH_ROI_OBSTACLE_STATS_ASSERT_SVH

// same-cycle implication
`define DROS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define DROS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/dros_pkg.sv
// ----------------------------------------------------------------------------
// dros_pkg
// Shared types and constants of the depth region obstacle statistics block.
// ----------------------------------------------------------------------------
package dros_pkg;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROI_X_LO  = 3'd0,
		CFG_ROI_X_HI  = 3'd1,
		CFG_ROI_Y_LO  = 3'd2,
		CFG_ROI_Y_HI  = 3'd3,
		CFG_PPY_Q4    = 3'd4,
		CFG_FLOOR_LIM = 3'd5,
		CFG_DETECT    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [10:0] roi_x_lo;
		logic [10:0] roi_x_hi;
		logic [10:0] roi_y_lo;
		logic [10:0] roi_y_hi;
		logic [14:0] ppy_q4;
		logic [23:0] floor_limit;
		logic [9:0]  detect_dist_raw;
	} cfg_t;

	localparam logic [10:0] RST_ROI_X_LO = 11'd0;
	localparam logic [10:0] RST_ROI_X_HI = 11'd640;
	localparam logic [10:0] RST_ROI_Y_LO = 11'd0;
	localparam logic [10:0] RST_ROI_Y_HI = 11'd480;
	localparam logic [14:0] RST_PPY_Q4   = 15'd3840;
	localparam logic [23:0] RST_FLOOR    = 24'd960000;
	localparam logic [9:0]  RST_DETECT   = 10'd500;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_RUN,
		ST_WAIT,
		ST_SCAN,
		ST_TAIL,
		ST_CALC
	} state_t;

	typedef struct packed {
		logic accept;
		logic sweep_clear;
		logic sweep_scan;
		logic calc;
	} cmd_t;

	typedef struct packed {
		logic fend_busy;
		logic frame_done;
		logic sweep_last;
		logic out_full;
	} sts_t;

endpackage

### rtl/dros_ctrl.sv
// ----------------------------------------------------------------------------
// dros_ctrl
// Sequencer: clear sweep after reset, pixel run, histogram scan, result load.
// ----------------------------------------------------------------------------
module dros_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  dros_pkg::sts_t  sts,
	output dros_pkg::cmd_t  cmd
);

	dros_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dros_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dros_pkg::ST_CLEAR: begin
				if (sts.sweep_last) state_d = dros_pkg::ST_RUN;
			end
			dros_pkg::ST_RUN: begin
				if (sts.frame_done) state_d = sts.out_full ? dros_pkg::ST_WAIT : dros_pkg::ST_SCAN;
			end
			dros_pkg::ST_WAIT: begin
				if (!sts.out_full) state_d = dros_pkg::ST_SCAN;
			end
			dros_pkg::ST_SCAN: begin
				if (sts.sweep_last) state_d = dros_pkg::ST_TAIL;
			end
			dros_pkg::ST_TAIL: state_d = dros_pkg::ST_CALC;
			dros_pkg::ST_CALC: state_d = dros_pkg::ST_RUN;
			default: state_d = dros_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			dros_pkg::ST_CLEAR: cmd.sweep_clear = 1'b1;
			dros_pkg::ST_RUN:   cmd.accept = !sts.fend_busy;
			dros_pkg::ST_SCAN:  cmd.sweep_scan = 1'b1;
			dros_pkg::ST_CALC:  cmd.calc = 1'b1;
			default:            cmd = '0;
		endcase
	end

endmodule

### rtl/dros_dp.sv
// ----------------------------------------------------------------------------
// dros_dp
// Pixel pipeline, histogram memory, frame counters, rank scan and result.
// ----------------------------------------------------------------------------
module dros_dp #(
	parameter int HIST_BINS     = 1024,
	parameter int COUNT_BITS    = 19,
	parameter int MIN_VALID_RAW = 10,
	parameter int MAX_VALID_RAW = 1000
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dros_pkg::cfg_t  cfg,
	input  dros_pkg::cmd_t  cmd,
	output dros_pkg::sts_t  sts,
	input  logic            in_valid,
	input  logic [15:0]     depth_raw,
	input  logic [10:0]     pixel_col,
	input  logic [10:0]     pixel_row,
	input  logic            frame_end,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            obstacle,
	output logic [9:0]      least_depth,
	output logic [13:0]     p10_tenths,
	output logic [10:0]     median_halves,
	output logic [18:0]     kept_count,
	output logic [18:0]     region_count,
	output logic [18:0]     near_count
);

	localparam int BIN_W = $clog2(HIST_BINS);
	localparam int CUM_W = COUNT_BITS + BIN_W;
	localparam int P_W   = BIN_W + 4;
	localparam int M_W   = BIN_W + 2;
	localparam int NX_W  = COUNT_BITS + 6;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(HIST_BINS - 1);

	// stage 1
	logic        vld_s1, fend_s1;
	logic [15:0] raw_s1;
	logic [10:0] col_s1, row_s1;
	logic        in_roi, raw_ok, floor_ok, keep_c, close_c;
	logic signed [16:0] dy;
	logic signed [33:0] prod;
	logic [BIN_W-1:0] bin_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid & cmd.accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && cmd.accept) begin
			raw_s1  <= depth_raw;
			col_s1  <= pixel_col;
			row_s1  <= pixel_row;
			fend_s1 <= frame_end;
		end
	end

	always_comb begin
		in_roi   = col_s1 >= cfg.roi_x_lo && col_s1 < cfg.roi_x_hi &&
		           row_s1 >= cfg.roi_y_lo && row_s1 < cfg.roi_y_hi;
		raw_ok   = raw_s1 >= 16'(MIN_VALID_RAW) && raw_s1 <= 16'(MAX_VALID_RAW);
		dy       = signed'({2'b0, row_s1, 4'b0}) - signed'({2'b0, cfg.ppy_q4});
		prod     = 34'(dy) * 34'(signed'({1'b0, raw_s1}));
		floor_ok = prod <= signed'({10'b0, cfg.floor_limit});
		keep_c   = in_roi & raw_ok & floor_ok;
		close_c  = raw_s1 <= {6'b0, cfg.detect_dist_raw};
		bin_c    = ({1'b0, raw_s1} < 17'(HIST_BINS)) ? BIN_W'(raw_s1) : BIN_LAST;
	end

	// stage 2
	logic             vld_s2, roi_s2, keep_s2, close_s2, fend_s2;
	logic [BIN_W-1:0] bin_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			roi_s2  <= 1'b0;
			keep_s2 <= 1'b0;
			fend_s2 <= 1'b0;
		end else begin
			vld_s2  <= vld_s1;
			roi_s2  <= vld_s1 & in_roi;
			keep_s2 <= vld_s1 & keep_c;
			fend_s2 <= vld_s1 & fend_s1;
		end
	end

	always_ff @(posedge clk) begin
		close_s2 <= close_c;
		bin_s2   <= bin_c;
	end

	// histogram memory
	logic [COUNT_BITS-1:0] hist_mem [HIST_BINS];
	logic [COUNT_BITS-1:0] rd_q, hist_cur, hist_new, wd;
	logic [BIN_W-1:0]      swp_q, ra, wa;
	logic                  we, sweeping, swp_last;
	logic                  lw_vld_q;
	logic [BIN_W-1:0]      lw_addr_q;
	logic [COUNT_BITS-1:0] lw_data_q;

	assign sweeping = cmd.sweep_clear | cmd.sweep_scan;
	assign swp_last = swp_q == BIN_LAST;
	assign hist_cur = (lw_vld_q && lw_addr_q == bin_s2) ? lw_data_q : rd_q;
	assign hist_new = (hist_cur < CNT_MAX) ? hist_cur + 1'b1 : hist_cur;

	always_comb begin
		ra = cmd.sweep_scan ? swp_q : bin_c;
		if (sweeping) begin
			we = 1'b1;
			wa = swp_q;
			wd = '0;
		end else begin
			we = keep_s2;
			wa = bin_s2;
			wd = hist_new;
		end
	end

	always_ff @(posedge clk) begin
		if (we) hist_mem[wa] <= wd;
		rd_q <= hist_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_vld_q <= 1'b0;
			swp_q    <= '0;
		end else begin
			lw_vld_q <= keep_s2 & ~sweeping;
			if (sweeping) swp_q <= swp_last ? '0 : swp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		lw_addr_q <= bin_s2;
		lw_data_q <= hist_new;
	end

	// frame counters
	logic [COUNT_BITS-1:0] region_q, kept_q, close_q, q10_q;
	logic [3:0]            r10_q;
	logic [9:0]            least_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
			kept_q   <= '0;
			close_q  <= '0;
			q10_q    <= '0;
			r10_q    <= '0;
			least_q  <= '1;
		end else if (cmd.calc) begin
			region_q <= '0;
			kept_q   <= '0;
			close_q  <= '0;
			q10_q    <= '0;
			r10_q    <= '0;
			least_q  <= '1;
		end else if (vld_s2) begin
			if (roi_s2 && region_q < CNT_MAX) region_q <= region_q + 1'b1;
			if (keep_s2) begin
				if (kept_q < CNT_MAX) begin
					kept_q <= kept_q + 1'b1;
					if (r10_q == 4'd9) begin
						r10_q <= '0;
						q10_q <= q10_q + 1'b1;
					end else begin
						r10_q <= r10_q + 1'b1;
					end
				end
				if (close_s2 && close_q < CNT_MAX) close_q <= close_q + 1'b1;
				if (16'(bin_s2) < 16'(least_q)) least_q <= 10'(bin_s2);
			end
		end
	end

	// rank scan
	logic [COUNT_BITS-1:0] m1, tgt [4];
	logic [3:0]            f10;
	logic                  sv_q;
	logic [BIN_W-1:0]      sidx_q, last_q;
	logic [BIN_W-1:0]      val_q [4];
	logic [BIN_W-1:0]      v [4];
	logic [3:0]            fnd_q;
	logic [CUM_W-1:0]      cum_q, cum_new;

	always_comb begin
		m1     = kept_q - 1'b1;
		tgt[0] = (r10_q == 4'd0) ? q10_q - 1'b1 : q10_q;
		f10    = (r10_q == 4'd0) ? 4'd9 : r10_q - 1'b1;
		tgt[1] = tgt[0] + 1'b1;
		tgt[2] = m1 >> 1;
		tgt[3] = tgt[2] + 1'b1;
		cum_new = cum_q + CUM_W'(rd_q);
		for (int j = 0; j < 4; j++) v[j] = fnd_q[j] ? val_q[j] : last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q  <= 1'b0;
			fnd_q <= '0;
			cum_q <= '0;
		end else begin
			sv_q <= cmd.sweep_scan;
			if (cmd.calc) begin
				fnd_q <= '0;
				cum_q <= '0;
			end else if (sv_q && rd_q != '0) begin
				cum_q <= cum_new;
				for (int j = 0; j < 4; j++) begin
					if (!fnd_q[j] && cum_new > CUM_W'(tgt[j])) fnd_q[j] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sidx_q <= swp_q;
		if (sv_q && rd_q != '0) begin
			last_q <= sidx_q;
			for (int j = 0; j < 4; j++) begin
				if (!fnd_q[j]) val_q[j] <= sidx_q;
			end
		end
	end

	// result
	logic [P_W-1:0] p10;
	logic [M_W-1:0] med;
	logic           nz, obst, out_valid_q;

	always_comb begin
		p10  = P_W'(v[0]) * P_W'(4'd10 - f10) + P_W'(v[1]) * P_W'(f10);
		med  = M_W'(v[2]) + M_W'(m1[0] ? v[3] : v[2]);
		nz   = kept_q != '0;
		obst = (NX_W'(kept_q) * NX_W'(50) > NX_W'(region_q)) &&
		       (20'(p10) <= 20'(cfg.detect_dist_raw) * 20'(10));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.calc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			obstacle      <= nz & obst;
			least_depth   <= nz ? least_q : '0;
			p10_tenths    <= nz ? 14'(p10) : '0;
			median_halves <= nz ? 11'(med) : '0;
			kept_count    <= 19'(kept_q);
			region_count  <= 19'(region_q);
			near_count    <= 19'(close_q);
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.fend_busy  = (vld_s1 & fend_s1) | fend_s2;
		sts.frame_done = fend_s2;
		sts.sweep_last = swp_last & sweeping;
		sts.out_full   = out_valid_q;
	end

endmodule

### rtl/depth_roi_obstacle_stats.sv
// ----------------------------------------------------------------------------
// depth_roi_obstacle_stats
// Region-of-interest depth statistics with obstacle flag, one result per frame.
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    depth_raw, pixel_col, pixel_row, frame_end
// out       output     out_valid / out_ready  obstacle .. near_count
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// One pixel per cycle while in_ready is high, through a two-stage read-modify-write
// on the histogram. After the frame-end transfer the input is held through the pipeline
// drain, the combined histogram scan and clear, a tail for the last read and the result
// load; out_valid rises at the end of the result load.
// After reset the whole histogram is cleared before the first pixel is accepted.
// A result not yet taken at a frame end holds the scan, and the input, until out_ready.
// ----------------------------------------------------------------------------
`include "depth_roi_obstacle_stats_assert.svh"

module depth_roi_obstacle_stats #(
	parameter int HIST_BINS     = 1024,
	parameter int COUNT_BITS    = 19,
	parameter int MIN_VALID_RAW = 10,
	parameter int MAX_VALID_RAW = 1000
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dros_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dros_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [15:0]                     depth_raw,
	input  logic [10:0]                     pixel_col,
	input  logic [10:0]                     pixel_row,
	input  logic                            frame_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            obstacle,
	output logic [9:0]                      least_depth,
	output logic [13:0]                     p10_tenths,
	output logic [10:0]                     median_halves,
	output logic [18:0]                     kept_count,
	output logic [18:0]                     region_count,
	output logic [18:0]                     near_count
);

	dros_pkg::cfg_t cfg_q;
	dros_pkg::cmd_t cmd;
	dros_pkg::sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roi_x_lo        <= dros_pkg::RST_ROI_X_LO;
			cfg_q.roi_x_hi        <= dros_pkg::RST_ROI_X_HI;
			cfg_q.roi_y_lo        <= dros_pkg::RST_ROI_Y_LO;
			cfg_q.roi_y_hi        <= dros_pkg::RST_ROI_Y_HI;
			cfg_q.ppy_q4          <= dros_pkg::RST_PPY_Q4;
			cfg_q.floor_limit     <= dros_pkg::RST_FLOOR;
			cfg_q.detect_dist_raw <= dros_pkg::RST_DETECT;
		end else if (cfg_we) begin
			unique case (dros_pkg::cfg_idx_t'(cfg_index))
				dros_pkg::CFG_ROI_X_LO:  cfg_q.roi_x_lo        <= cfg_data[10:0];
				dros_pkg::CFG_ROI_X_HI:  cfg_q.roi_x_hi        <= cfg_data[10:0];
				dros_pkg::CFG_ROI_Y_LO:  cfg_q.roi_y_lo        <= cfg_data[10:0];
				dros_pkg::CFG_ROI_Y_HI:  cfg_q.roi_y_hi        <= cfg_data[10:0];
				dros_pkg::CFG_PPY_Q4:    cfg_q.ppy_q4          <= cfg_data[14:0];
				dros_pkg::CFG_FLOOR_LIM: cfg_q.floor_limit     <= cfg_data[23:0];
				dros_pkg::CFG_DETECT:    cfg_q.detect_dist_raw <= cfg_data[9:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	dros_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	dros_dp #(
		.HIST_BINS     (HIST_BINS),
		.COUNT_BITS    (COUNT_BITS),
		.MIN_VALID_RAW (MIN_VALID_RAW),
		.MAX_VALID_RAW (MAX_VALID_RAW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.in_valid      (in_valid),
		.depth_raw     (depth_raw),
		.pixel_col     (pixel_col),
		.pixel_row     (pixel_row),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.obstacle      (obstacle),
		.least_depth   (least_depth),
		.p10_tenths    (p10_tenths),
		.median_halves (median_halves),
		.kept_count    (kept_count),
		.region_count  (region_count),
		.near_count    (near_count)
	);

	assign in_ready = cmd.accept;

	`DROS_ASSERT_NEXT(a_calc_loads_result, cmd.calc, out_valid)
	`DROS_ASSERT_NEXT(a_fend_blocks_input, in_valid && in_ready && frame_end, !in_ready)
	`DROS_ASSERT_NOW(a_cmd_exclusive, 1'b1,
		$onehot0({cmd.accept, cmd.sweep_clear, cmd.sweep_scan, cmd.calc}))

endmodule
